### rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and helpers of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// fixed point: ONE = 2^FRAC_BITS means 1.0
	localparam int FRAC_BITS = 8;
	localparam int UNIT_W    = FRAC_BITS + 1;     // holds 0..ONE
	localparam int PROD_W    = 2 * UNIT_W;

	localparam int HUE_W   = 16;
	localparam int SV_W    = 10;
	localparam int CHAN_W  = 8;

	localparam int DegFull   = 360;
	localparam int SectorDeg = 60;

	// hue + HueOffset is never negative and keeps its residue mod 360
	localparam int HueOffset = 92 * DegFull;
	localparam int WRAP_W    = 17;
	localparam int RecipShift = 24;
	localparam int RecipDeg   = (1 << RecipShift) / DegFull;   // floor, never overshoots
	localparam int RECIP_W    = 16;
	localparam int WPROD_W    = WRAP_W + RECIP_W;
	localparam int DEG_W      = 9;                 // 0..359
	localparam int QUOT_W     = 9;
	localparam int POS_W      = 6;                 // 0..59

	typedef logic [UNIT_W-1:0]    unit_t;
	typedef logic [FRAC_BITS-1:0] frac_t;

	localparam unit_t ONE_FX = unit_t'(1) << FRAC_BITS;

	typedef enum logic [2:0] {
		SEC_0 = 3'd0,
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5
	} sector_t;

	// classified item passed from front to back
	typedef struct packed {
		sector_t sector;
		frac_t   frac;
		unit_t   sat;
		unit_t   val;
	} hsv_item_t;

	typedef frac_t frac_lut_t [SectorDeg];

	// fraction within a sector: (pos << FRAC_BITS) / 60, truncated
	function automatic frac_lut_t build_frac_lut();
		frac_lut_t lut;
		for (int i = 0; i < SectorDeg; i++) begin
			lut[i] = frac_t'((i << FRAC_BITS) / SectorDeg);
		end
		return lut;
	endfunction

	localparam frac_lut_t FRAC_LUT = build_frac_lut();

	// clamp a signed fixed point input into 0..ONE
	function automatic unit_t clamp_unit(logic signed [SV_W-1:0] x);
		unit_t r;
		if (x[SV_W-1]) begin
			r = '0;
		end else if (int'(x) > (1 << FRAC_BITS)) begin
			r = ONE_FX;
		end else begin
			r = unit_t'(unsigned'(x));
		end
		return r;
	endfunction

	// (c * 255) >> FRAC_BITS, low byte
	function automatic logic [CHAN_W-1:0] to_byte(unit_t c);
		logic [UNIT_W+7:0] x;
		x = {c, 8'b0} - (UNIT_W + 8)'(c);
		return x[FRAC_BITS +: CHAN_W];
	endfunction

endpackage

### rtl/hsv2rgb_front.sv
// ----------------------------------------------------------------------------
// hsv2rgb_front
// Takes input items, wraps hue, clamps s/v, finds sector and fraction.
// ----------------------------------------------------------------------------
module hsv2rgb_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [hsv2rgb_pkg::HUE_W-1:0]  hue,
	input  logic signed [hsv2rgb_pkg::SV_W-1:0]   saturation,
	input  logic signed [hsv2rgb_pkg::SV_W-1:0]   brightness,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output hsv2rgb_pkg::hsv_item_t                out_item
);
	import hsv2rgb_pkg::*;

	logic                valid_s1, valid_s2, valid_s3;
	logic                adv1, adv2, adv3;
	logic [WRAP_W-1:0]   wrap_s1;
	logic [WPROD_W-1:0]  wprod_s1;
	unit_t               sat_s1, val_s1, sat_s2, val_s2;
	logic [DEG_W-1:0]    deg_s2;
	hsv_item_t           item_s3;

	logic [WRAP_W-1:0]   wrap_d;
	logic [QUOT_W-1:0]   quot;
	logic [WRAP_W-1:0]   rem;
	logic [DEG_W-1:0]    deg_d;
	sector_t             sector_d;
	logic [DEG_W-1:0]    base_d;
	logic [POS_W-1:0]    pos_d;

	// ready chain: a stage moves when it is empty or the next one moves
	assign adv3     = !valid_s3 || out_ready;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	// stage 1: bias hue positive, multiply by reciprocal of 360
	assign wrap_d = {{(WRAP_W - HUE_W){hue[HUE_W-1]}}, hue} + WRAP_W'(HueOffset);

	// stage 2: remainder with one correction step
	assign quot = wprod_s1[RecipShift +: QUOT_W];
	assign rem  = wrap_s1 - (WRAP_W'(quot) * WRAP_W'(DegFull));
	always_comb begin
		if (rem >= WRAP_W'(DegFull)) begin
			deg_d = DEG_W'(rem - WRAP_W'(DegFull));
		end else begin
			deg_d = DEG_W'(rem);
		end
	end

	// stage 3: sector and position inside it
	always_comb begin
		if (deg_s2 >= DEG_W'(5 * SectorDeg)) begin
			sector_d = SEC_5;
			base_d   = DEG_W'(5 * SectorDeg);
		end else if (deg_s2 >= DEG_W'(4 * SectorDeg)) begin
			sector_d = SEC_4;
			base_d   = DEG_W'(4 * SectorDeg);
		end else if (deg_s2 >= DEG_W'(3 * SectorDeg)) begin
			sector_d = SEC_3;
			base_d   = DEG_W'(3 * SectorDeg);
		end else if (deg_s2 >= DEG_W'(2 * SectorDeg)) begin
			sector_d = SEC_2;
			base_d   = DEG_W'(2 * SectorDeg);
		end else if (deg_s2 >= DEG_W'(SectorDeg)) begin
			sector_d = SEC_1;
			base_d   = DEG_W'(SectorDeg);
		end else begin
			sector_d = SEC_0;
			base_d   = '0;
		end
		pos_d = POS_W'(deg_s2 - base_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			wrap_s1  <= wrap_d;
			wprod_s1 <= WPROD_W'(wrap_d) * WPROD_W'(RecipDeg);
			sat_s1   <= clamp_unit(saturation);
			val_s1   <= clamp_unit(brightness);
		end
		if (adv2) begin
			deg_s2 <= deg_d;
			sat_s2 <= sat_s1;
			val_s2 <= val_s1;
		end
		if (adv3) begin
			item_s3.sector <= sector_d;
			item_s3.frac   <= FRAC_LUT[pos_d];
			item_s3.sat    <= sat_s2;
			item_s3.val    <= val_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

### rtl/hsv2rgb_queue.sv
// ----------------------------------------------------------------------------
// hsv2rgb_queue
// Two-entry item queue between front and back.
// ----------------------------------------------------------------------------
module hsv2rgb_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  hsv2rgb_pkg::hsv_item_t in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output hsv2rgb_pkg::hsv_item_t out_item
);
	import hsv2rgb_pkg::*;

	hsv_item_t  slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= in_item;
	end

endmodule

### rtl/hsv2rgb_back.sv
// ----------------------------------------------------------------------------
// hsv2rgb_back
// Forms p, q, t, routes them by sector and scales to bytes.
// ----------------------------------------------------------------------------
module hsv2rgb_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  hsv2rgb_pkg::hsv_item_t              in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]      red,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]      green,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]      blue
);
	import hsv2rgb_pkg::*;

	logic               valid_s1, valid_s2, valid_s3;
	logic               adv1, adv2, adv3;
	logic [PROD_W-1:0]  pn_s1, sf_s1, sg_s1;
	unit_t              val_s1, val_s2, p_s2;
	sector_t            sector_s1, sector_s2;
	logic [PROD_W-1:0]  qn_s2, tn_s2;
	logic [CHAN_W-1:0]  red_s3, green_s3, blue_s3;

	unit_t              qa, ta, q_c, t_c, r_c, g_c, b_c;

	assign adv3     = !valid_s3 || out_ready;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	// stage 2 operands: 1 - s*f and 1 - s*(1-f)
	assign qa = ONE_FX - sf_s1[FRAC_BITS +: UNIT_W];
	assign ta = ONE_FX - sg_s1[FRAC_BITS +: UNIT_W];

	// stage 3: finish q, t and route
	assign q_c = qn_s2[FRAC_BITS +: UNIT_W];
	assign t_c = tn_s2[FRAC_BITS +: UNIT_W];

	always_comb begin
		case (sector_s2)
			SEC_1: begin
				r_c = q_c;    g_c = val_s2; b_c = p_s2;
			end
			SEC_2: begin
				r_c = p_s2;   g_c = val_s2; b_c = t_c;
			end
			SEC_3: begin
				r_c = p_s2;   g_c = q_c;    b_c = val_s2;
			end
			SEC_4: begin
				r_c = t_c;    g_c = p_s2;   b_c = val_s2;
			end
			SEC_5: begin
				r_c = val_s2; g_c = p_s2;   b_c = q_c;
			end
			default: begin
				r_c = val_s2; g_c = t_c;    b_c = p_s2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			pn_s1     <= PROD_W'(in_item.val) * PROD_W'(ONE_FX - in_item.sat);
			sf_s1     <= PROD_W'(in_item.sat) * PROD_W'(in_item.frac);
			sg_s1     <= PROD_W'(in_item.sat) * PROD_W'(ONE_FX - UNIT_W'(in_item.frac));
			val_s1    <= in_item.val;
			sector_s1 <= in_item.sector;
		end
		if (adv2) begin
			p_s2      <= pn_s1[FRAC_BITS +: UNIT_W];
			qn_s2     <= PROD_W'(val_s1) * PROD_W'(qa);
			tn_s2     <= PROD_W'(val_s1) * PROD_W'(ta);
			val_s2    <= val_s1;
			sector_s2 <= sector_s1;
		end
		if (adv3) begin
			red_s3   <= to_byte(r_c);
			green_s3 <= to_byte(g_c);
			blue_s3  <= to_byte(b_c);
		end
	end

	assign out_valid = valid_s3;
	assign red       = red_s3;
	assign green     = green_s3;
	assign blue      = blue_s3;

endmodule

### rtl/hsv2rgb_converter_top.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// HSV to 8-bit RGB colour converter with stream input and output.
// ----------------------------------------------------------------------------
// Accepts one HSV item per clock and returns one RGB item per clock. Hue is
// any signed degree value and is wrapped into 0..359; saturation and value
// are fixed point with 256 = 1.0 and are clamped to 0..256. Each channel is
// the routed component times 255, truncated. The path from input accept to
// output valid is a 3-stage front (hue wrap by reciprocal multiply,
// remainder, sector/fraction lookup), the registered 2-entry queue, and a
// 3-stage back (products, p/q/t, route and scale). No stage shares a unit
// between items, so throughput is one item per clock. Backpressure on the
// output stalls the back first; the queue and front keep absorbing items
// until they fill. No configuration.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // hue[15:0], saturation[25:16],
	                                    // brightness[35:26], zero[39:36]
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);
	import hsv2rgb_pkg::*;

	logic      fq_valid, fq_ready;
	hsv_item_t fq_item;
	logic      qb_valid, qb_ready;
	hsv_item_t qb_item;

	logic [CHAN_W-1:0] red, green, blue;

	// front: wrap, clamp, classify into sector
	hsv2rgb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.hue        (s_axis_tdata[15:0]),
		.saturation (s_axis_tdata[25:16]),
		.brightness (s_axis_tdata[35:26]),
		.out_valid  (fq_valid),
		.out_ready  (fq_ready),
		.out_item   (fq_item)
	);

	// short queue decouples front and back stalls
	hsv2rgb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (fq_item),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_item  (qb_item)
	);

	// back: p/q/t, routing, scaling; last stage is the output register
	hsv2rgb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (qb_valid),
		.in_ready  (qb_ready),
		.in_item   (qb_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	assign m_axis_tdata = {blue, green, red};

endmodule

### test/tb_hsv_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_top
// Self-checking stream testbench for the HSV to RGB converter.
// ----------------------------------------------------------------------------
// A queue of HSV items feeds a clocked driver on the input stream. A clocked
// monitor predicts the RGB item for every accepted input and checks each
// accepted output against the oldest prediction, channel by channel. The run
// walks through a directed set of corner colors and then three random phases
// with different idle mixes on either side, including one long output stall
// that backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_top;

	import hsv2rgb_pkg::*;

	// one input item; hue ends up in the low bits of the packed vector
	typedef struct packed {
		logic signed [SV_W-1:0]  brightness;
		logic signed [SV_W-1:0]  saturation;
		logic signed [HUE_W-1:0] hue;
	} hsv_t;

	// one result item; red in the low byte
	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

	localparam int ClkHalf     = 4;
	localparam int LongStall   = 60;    // cycles the receiver holds off
	localparam int DrainCycles = 20;    // longer than the pipeline latency

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;     // hue[15:0], saturation[25:16],
	                                    // brightness[35:26], zero[39:36]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;          // red[7:0], green[15:8], blue[23:16]

	hsv_t hsv_stim_q[$];                // items waiting to be offered
	rgb_t rgb_expected_q[$];            // predicted colors in output order

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   stall_req = 0;                // bumped to ask for one long stall
	int   stall_ack = 0;
	int   stall_left = 0;
	logic in_fire = 1'b0;               // input handshake at the last rising edge

	int   error_count = 0;
	int   items_in = 0;
	int   colors_checked = 0;
	int   sector_hits [6];
	int   clamp_hits = 0;

	hsv_to_rgb_converter_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#ClkHalf clk = 1'b1;
		#ClkHalf clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// saturation / value into 0..ONE
	function automatic int unit_level(logic signed [SV_W-1:0] x);
		int n;
		n = int'(x);
		if (n < 0) begin
			n = 0;
		end else if (n > int'(ONE_FX)) begin
			n = int'(ONE_FX);
		end
		return n;
	endfunction

	function automatic logic [CHAN_W-1:0] chan_byte(int c);
		return CHAN_W'((c * 255) >> FRAC_BITS);
	endfunction

	function automatic rgb_t rgb_of_hsv(hsv_t x);
		int      one, deg, s, v, frac, p, q, t, r, g, b;
		sector_t sec;
		rgb_t    y;
		one  = int'(ONE_FX);
		deg  = int'(x.hue) % DegFull;      // sign follows the dividend
		if (deg < 0) begin
			deg += DegFull;
		end
		s    = unit_level(x.saturation);
		v    = unit_level(x.brightness);
		sec  = sector_t'(deg / SectorDeg);
		frac = ((deg % SectorDeg) << FRAC_BITS) / SectorDeg;
		p    = (v * (one - s)) >> FRAC_BITS;
		q    = (v * (one - ((s * frac) >> FRAC_BITS))) >> FRAC_BITS;
		t    = (v * (one - ((s * (one - frac)) >> FRAC_BITS))) >> FRAC_BITS;
		case (sec)
			SEC_1: begin r = q; g = v; b = p; end
			SEC_2: begin r = p; g = v; b = t; end
			SEC_3: begin r = p; g = q; b = v; end
			SEC_4: begin r = t; g = p; b = v; end
			SEC_5: begin r = v; g = p; b = q; end
			default: begin r = v; g = t; b = p; end
		endcase
		y.red   = chan_byte(r);
		y.green = chan_byte(g);
		y.blue  = chan_byte(b);
		return y;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic hsv_t mk_hsv(int h, int s, int v);
		hsv_t x;
		x.hue        = HUE_W'(h);
		x.saturation = SV_W'(s);
		x.brightness = SV_W'(v);
		return x;
	endfunction

	// append one item to the pending stimulus
	task automatic add_stim(int h, int s, int v);
		hsv_stim_q.insert(hsv_stim_q.size(), mk_hsv(h, s, v));
	endtask

	// saturation / value: mostly the legal range, plus clamp edges and noise
	function automatic int rand_level();
		int n;
		case ($urandom_range(0, 4))
			0:       n = int'($urandom_range(0, 1023)) - 512;  // any 10-bit value
			1:       n = $urandom_range(0, 1) ? int'(ONE_FX) : 0;
			2:       n = int'(ONE_FX) - 4 + int'($urandom_range(0, 8));
			default: n = $urandom_range(0, int'(ONE_FX));
		endcase
		return n;
	endfunction

	function automatic int rand_hue();
		int n;
		case ($urandom_range(0, 3))
			0, 1:    n = int'($urandom_range(0, 65535)) - 32768;
			2:       n = $urandom_range(0, DegFull - 1);
			default: n = int'($urandom_range(0, 4 * DegFull)) - 2 * DegFull;
		endcase
		return n;
	endfunction

	task automatic queue_random(int count);
		for (int i = 0; i < count; i++) begin
			add_stim(rand_hue(), rand_level(), rand_level());
		end
	endtask

	// hold the sender until everything offered has come back out
	task automatic wait_drained();
		while (hsv_stim_q.size() != 0 || s_axis_tvalid || rgb_expected_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic check_chan(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: one item per free cycle, random gaps, changes on the falling edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		hsv_t nxt;
		if (arst_n) begin
			// the slot is free once the held item was taken or nothing is held
			if (!s_axis_tvalid || in_fire) begin
				if (hsv_stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = hsv_stim_q.pop_front();
					s_axis_tdata  <= {4'b0, nxt};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random ready, or a long counted hold-off on request
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_req != stall_ack) begin
				stall_ack     <= stall_req;
				stall_left    <= LongStall - 1;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left    <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: predict on input accept, compare on output accept
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		hsv_t acc;
		rgb_t got;
		rgb_t want;
		int   deg;
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				acc = hsv_t'(s_axis_tdata[35:0]);
				rgb_expected_q.insert(rgb_expected_q.size(), rgb_of_hsv(acc));
				items_in++;
				deg = int'(acc.hue) % DegFull;
				if (deg < 0) begin
					deg += DegFull;
				end
				sector_hits[deg / SectorDeg]++;
				if (unit_level(acc.saturation) != int'(acc.saturation) ||
				    unit_level(acc.brightness) != int'(acc.brightness)) begin
					clamp_hits++;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = rgb_t'(m_axis_tdata);
				if (rgb_expected_q.size() == 0) begin
					error_count++;
					$display("%0t unexpected color: expected none actual %h", $time, got);
				end else begin
					want = rgb_expected_q.pop_front();
					check_chan("red",   want.red,   got.red);
					check_chan("green", want.green, got.green);
					check_chan("blue",  want.blue,  got.blue);
					colors_checked++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		for (int i = 0; i < 6; i++) begin
			sector_hits[i] = 0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: hue extremes and wrap points, one item per sector,
		// clamps on both ends of saturation and value
		add_stim(-32768, 256, 256);
		add_stim(32767, 256, 256);
		add_stim(0, 256, 256);
		add_stim(59, 256, 256);
		add_stim(60, 256, 256);
		add_stim(359, 256, 256);
		add_stim(360, 256, 256);
		add_stim(-1, 256, 256);
		add_stim(-360, 200, 180);
		add_stim(-361, 200, 180);
		for (int sct = 0; sct < 6; sct++) begin
			add_stim(sct * SectorDeg + 37, 190, 230);
		end
		add_stim(100, -512, 200);   // saturation below zero
		add_stim(100, 511, 200);    // saturation above one
		add_stim(100, 257, 200);
		add_stim(200, 128, -512);   // value below zero
		add_stim(200, 128, 511);    // value above one
		add_stim(200, 128, 257);
		add_stim(300, 0, 0);
		add_stim(-32768, -1, -1);
		add_stim(32767, 511, 511);
		wait_drained();

		// sender gaps light, receiver mostly stalled
		send_idle_pct = 27;
		recv_idle_pct = 62;
		queue_random(310);
		wait_drained();

		// the other way round
		send_idle_pct = 62;
		recv_idle_pct = 27;
		queue_random(310);
		wait_drained();

		// no idling; one long output hold-off while input keeps coming, so
		// the pipeline and queue fill and input ready drops
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(310);
		repeat (5) @(posedge clk);
		stall_req = stall_req + 1;
		wait_drained();

		repeat (DrainCycles) @(posedge clk);
		if (rgb_expected_q.size() != 0) begin
			error_count++;
			$display("%0t missing colors: expected %0d more actual 0", $time,
			         rgb_expected_q.size());
		end
		$display("run covered %0d items, %0d colors checked, %0d with clamped inputs",
		         items_in, colors_checked, clamp_hits);
		$display("sector counts %0d %0d %0d %0d %0d %0d, %0d mismatches", sector_hits[0],
		         sector_hits[1], sector_hits[2], sector_hits[3], sector_hits[4],
		         sector_hits[5], error_count);
		if (error_count == 0) begin
			$display("tb_hsv_to_rgb_converter_top: PASS");
		end else begin
			$display("tb_hsv_to_rgb_converter_top: FAIL");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#(2 * ClkHalf * 400000);
		$display("%0t timeout with %0d colors outstanding", $time, rgb_expected_q.size());
		$display("tb_hsv_to_rgb_converter_top: FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_front.sv
rtl/hsv2rgb_queue.sv
rtl/hsv2rgb_back.sv
rtl/hsv2rgb_converter_top.sv
test/tb_hsv_to_rgb_converter_top.sv
